// ===== hdl/mmbd_pkg.sv =====
// shared types, constants and pixel arithmetic for the mip chain downsampler
package mmbd_pkg;

   localparam int CFG_W     = 4;
   localparam int LEVEL_W   = 4;
   localparam int COORD_W   = 12;
   localparam int POS_W     = 11;
   localparam int CHAN_W    = 8;
   localparam int PAIR_W    = CHAN_W + 1;
   localparam int SIDE_LOG2_MAX = 12;

   // register indexes on the configuration port
   localparam logic [1:0] REG_WIDTH_LOG2  = 2'd0;
   localparam logic [1:0] REG_HEIGHT_LOG2 = 2'd1;
   localparam logic [1:0] REG_LEVEL_COUNT = 2'd2;

   typedef struct packed {
      logic [CHAN_W-1:0] red;
      logic [CHAN_W-1:0] green;
      logic [CHAN_W-1:0] blue;
      logic [CHAN_W-1:0] alpha;
   } pixel_type;

   typedef struct packed {
      logic [LEVEL_W-1:0] level;
      logic [POS_W-1:0]   px;
      logic [POS_W-1:0]   py;
      logic [CHAN_W-1:0]  avg_red;
      logic [CHAN_W-1:0]  avg_green;
      logic [CHAN_W-1:0]  avg_blue;
      logic [CHAN_W-1:0]  avg_alpha;
      logic               last;
   } result_type;

   // per-channel sum of the two pixels of an even-row pair
   typedef struct packed {
      logic [PAIR_W-1:0] red;
      logic [PAIR_W-1:0] green;
      logic [PAIR_W-1:0] blue;
      logic [PAIR_W-1:0] alpha;
   } pair_sum_type;

   // what the level stage decided for the current token
   typedef struct packed {
      logic             made;
      logic [POS_W-1:0] px;
      logic [POS_W-1:0] py;
      pixel_type        held;
   } step_type;

   function automatic pair_sum_type pair_add(pixel_type a, pixel_type b);
      pair_sum_type s;
      s.red   = {1'b0, a.red}   + {1'b0, b.red};
      s.green = {1'b0, a.green} + {1'b0, b.green};
      s.blue  = {1'b0, a.blue}  + {1'b0, b.blue};
      s.alpha = {1'b0, a.alpha} + {1'b0, b.alpha};
      return s;
   endfunction

   function automatic logic [CHAN_W-1:0] chan_avg(logic [PAIR_W-1:0] p,
                                                  logic [CHAN_W-1:0] a,
                                                  logic [CHAN_W-1:0] b);
      logic [CHAN_W+1:0] sum;
      sum = {1'b0, p} + {2'b00, a} + {2'b00, b};
      return sum[CHAN_W+1:2];
   endfunction

   function automatic pixel_type quad_average(pair_sum_type p, pixel_type a, pixel_type b);
      pixel_type r;
      r.red   = chan_avg(p.red,   a.red,   b.red);
      r.green = chan_avg(p.green, a.green, b.green);
      r.blue  = chan_avg(p.blue,  a.blue,  b.blue);
      r.alpha = chan_avg(p.alpha, a.alpha, b.alpha);
      return r;
   endfunction

endpackage

// ===== hdl/mmbd_row_store.sv =====
// single-port row store holding even-row pair sums of every source level
module mmbd_row_store #(
   parameter int AW = 12
) (
   input  logic                  clock,
   input  logic                  wr_en,
   input  logic                  rd_en,
   input  logic [AW-1:0]         addr,
   input  mmbd_pkg::pair_sum_type wr_data,
   output mmbd_pkg::pair_sum_type rd_data
);
   import mmbd_pkg::*;

   localparam int DEPTH = 1 << AW;

   pair_sum_type mem_ff [DEPTH];
   pair_sum_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/mmbd_level_stage.sv =====
// per-level position counters, held left pixels and row store addressing
module mmbd_level_stage #(
   parameter int MAX_LEVELS = 12,
   parameter int AW         = 12
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         clear,
   input  logic                         fire,
   input  logic [mmbd_pkg::LEVEL_W-1:0] level,
   input  mmbd_pkg::pixel_type          pixel,
   input  logic [mmbd_pkg::CFG_W-1:0]   levels,
   input  logic [mmbd_pkg::CFG_W-1:0]   wl,
   input  logic [mmbd_pkg::CFG_W-1:0]   hl,
   output mmbd_pkg::step_type           step,
   output logic                         mem_wr_en,
   output logic                         mem_rd_en,
   output logic [AW-1:0]                mem_addr,
   output mmbd_pkg::pair_sum_type       mem_wr_data
);
   import mmbd_pkg::*;

   localparam int IW    = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
   localparam int EFF_W = 1 << AW;

   logic [COORD_W-1:0] col_ff [MAX_LEVELS];
   logic [COORD_W-1:0] row_ff [MAX_LEVELS];
   pixel_type          held_ff [MAX_LEVELS];

   logic [IW-1:0]      idx;
   logic               active;
   logic [COORD_W-1:0] x, y;
   logic [COORD_W-1:0] col_in, row_in;
   logic [CFG_W-1:0]   w_shift, h_shift;
   logic [COORD_W:0]   w_full, h_full;
   logic               x_last, y_last;
   logic [AW:0]        base;

   assign idx    = level[IW-1:0];
   assign active = (level < levels);
   assign x      = col_ff[idx];
   assign y      = row_ff[idx];

   // side of this level is 1 << (log2 side - level)
   assign w_shift = wl - level;
   assign h_shift = hl - level;
   assign w_full  = (COORD_W+1)'(1) << w_shift;
   assign h_full  = (COORD_W+1)'(1) << h_shift;
   assign x_last  = (x == COORD_W'(w_full - (COORD_W+1)'(1)));
   assign y_last  = (y == COORD_W'(h_full - (COORD_W+1)'(1)));

   always_comb begin
      col_in = x + COORD_W'(1);
      row_in = y;
      if (x_last) begin
         col_in = '0;
         row_in = y_last ? '0 : y + COORD_W'(1);
      end
   end

   // each level gets a region of half its maximum width
   assign base = (AW+1)'(EFF_W) - ((AW+1)'(EFF_W) >> level);
   assign mem_addr = AW'(base) + AW'(x >> 1);

   assign step.made = active && x[0] && y[0];
   assign step.px   = x[COORD_W-1:1];
   assign step.py   = y[COORD_W-1:1];
   assign step.held = held_ff[idx];

   assign mem_wr_en   = fire && active && x[0] && !y[0];
   assign mem_rd_en   = fire && step.made;
   assign mem_wr_data = pair_add(held_ff[idx], pixel);

   always_ff @(posedge clock) begin
      if (reset || clear) begin
         for (int i = 0; i < MAX_LEVELS; i++) begin
            col_ff[i] <= '0;
            row_ff[i] <= '0;
         end
      end else if (fire && active) begin
         col_ff[idx] <= col_in;
         row_ff[idx] <= row_in;
      end
   end

   // left pixel of each pair, used on even rows and odd rows alike
   always_ff @(posedge clock) begin
      if (fire && active && !x[0]) begin
         held_ff[idx] <= pixel;
      end
   end

endmodule

// ===== hdl/mmbd_rsp_fifo.sv =====
// two-entry result queue that decouples the pipeline from the receiver
module mmbd_rsp_fifo (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  mmbd_pkg::result_type push_data,
   output logic                 full,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output mmbd_pkg::result_type rsp_data
);
   import mmbd_pkg::*;

   result_type slot_ff [2];
   logic       wr_ptr_ff, rd_ptr_ff;
   logic [1:0] count_ff, count_in;
   logic       pop;

   assign rsp_valid = (count_ff != 2'd0);
   assign full      = (count_ff == 2'd2);
   assign pop       = rsp_valid && rsp_ready;
   assign rsp_data  = slot_ff[rd_ptr_ff];
   assign count_in  = count_ff + {1'b0, push} - {1'b0, pop};

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== hdl/mipmap_box_downsampler.sv =====
// top level of the streaming 2x2 box-filter mip chain downsampler
//
// req channel: one level-0 RGBA pixel per transaction, raster order.
// rsp channel: one downsampled pixel per transaction with its level, px, py
// and a last flag on the final result caused by an input pixel.
// csr port: APB-style, width_log2 at 0x0, height_log2 at 0x4, level_count
// at 0x8; any write of these restarts the image at pixel zero.
// A pixel that finishes no coarser pixel is taken every cycle while the level
// pipeline is free. A pixel that finishes pixels on k levels occupies the
// level pipeline until its last level is done: each level is a row store
// read in stage a and the averaging in stage b, and a finished pixel loops
// back as the source of the next level. A result is registered in stage a
// with the next level's token and is pushed when that token fires.
// Results wait in a two-entry queue, so a stalled receiver holds back the
// pipeline only once the queue is full; nothing is dropped.
// Reset clears the counters, the pipeline and the queue; registers return
// to 8. The row store needs no clearing, it is always written before read.
module mipmap_box_downsampler #(
   parameter int MAX_WIDTH  = 4096,
   parameter int MAX_LEVELS = 12
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  mmbd_pkg::pixel_type  req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output mmbd_pkg::result_type rsp_data,
   input  logic                 psel,
   input  logic                 penable,
   input  logic                 pwrite,
   input  logic [3:0]           paddr,
   input  logic [31:0]          pwdata,
   output logic [31:0]          prdata,
   output logic                 pready
);
   import mmbd_pkg::*;

   localparam int WL_FLOOR = $clog2(MAX_WIDTH + 1) - 1;
   localparam int WL_MAX   = (WL_FLOOR > SIDE_LOG2_MAX) ? SIDE_LOG2_MAX : WL_FLOOR;
   localparam int AW       = WL_MAX;

   // configuration registers
   logic [CFG_W-1:0] width_log2_ff, height_log2_ff, level_count_ff;
   logic             csr_write, csr_clear;
   logic [1:0]       csr_index;

   logic [CFG_W-1:0] wl, hl, lv_a, lv_b, levels;

   // level pipeline: one token, in stage a or stage b
   logic                a_valid_ff, a_valid_in;
   logic [LEVEL_W-1:0]  a_level_ff, a_level_in;
   pixel_type           a_pixel_ff, a_pixel_in;
   logic                a_has_prev_ff, a_has_prev_in;
   result_type          a_prev_ff, a_prev_in;

   logic                b_valid_ff;
   logic [LEVEL_W-1:0]  b_level_ff;
   logic [POS_W-1:0]    b_px_ff, b_py_ff;
   pixel_type           b_held_ff, b_pixel_ff;

   step_type            step;
   logic                a_fire, req_take, fifo_full, push;
   result_type          push_data, cascade;
   pixel_type           avg;
   logic [LEVEL_W-1:0]  next_level;

   logic                mem_wr_en, mem_rd_en;
   logic [AW-1:0]       mem_addr;
   pair_sum_type        mem_wr_data, mem_rd_data;

   assign csr_write = psel && penable && pwrite;
   assign csr_index = paddr[3:2];
   assign csr_clear = csr_write && (csr_index == REG_WIDTH_LOG2 ||
                                    csr_index == REG_HEIGHT_LOG2 ||
                                    csr_index == REG_LEVEL_COUNT);
   assign pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         width_log2_ff  <= CFG_W'(8);
         height_log2_ff <= CFG_W'(8);
         level_count_ff <= CFG_W'(8);
      end else if (csr_write) begin
         case (csr_index)
            REG_WIDTH_LOG2:  width_log2_ff  <= pwdata[CFG_W-1:0];
            REG_HEIGHT_LOG2: height_log2_ff <= pwdata[CFG_W-1:0];
            REG_LEVEL_COUNT: level_count_ff <= pwdata[CFG_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         REG_WIDTH_LOG2:  prdata = {{(32-CFG_W){1'b0}}, width_log2_ff};
         REG_HEIGHT_LOG2: prdata = {{(32-CFG_W){1'b0}}, height_log2_ff};
         REG_LEVEL_COUNT: prdata = {{(32-CFG_W){1'b0}}, level_count_ff};
         default:         prdata = '0;
      endcase
   end

   // a level exists only while its source is at least 2 by 2
   assign wl     = (width_log2_ff > CFG_W'(WL_MAX)) ? CFG_W'(WL_MAX) : width_log2_ff;
   assign hl     = (height_log2_ff > CFG_W'(SIDE_LOG2_MAX)) ?
                   CFG_W'(SIDE_LOG2_MAX) : height_log2_ff;
   assign lv_a   = (level_count_ff > CFG_W'(MAX_LEVELS)) ? CFG_W'(MAX_LEVELS) : level_count_ff;
   assign lv_b   = (wl < hl) ? wl : hl;
   assign levels = (lv_a < lv_b) ? lv_a : lv_b;

   mmbd_level_stage #(
      .MAX_LEVELS (MAX_LEVELS),
      .AW         (AW)
   ) u_level_stage (
      .clock       (clock),
      .reset       (reset),
      .clear       (csr_clear),
      .fire        (a_fire),
      .level       (a_level_ff),
      .pixel       (a_pixel_ff),
      .levels      (levels),
      .wl          (wl),
      .hl          (hl),
      .step        (step),
      .mem_wr_en   (mem_wr_en),
      .mem_rd_en   (mem_rd_en),
      .mem_addr    (mem_addr),
      .mem_wr_data (mem_wr_data)
   );

   mmbd_row_store #(
      .AW (AW)
   ) u_row_store (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .rd_en   (mem_rd_en),
      .addr    (mem_addr),
      .wr_data (mem_wr_data),
      .rd_data (mem_rd_data)
   );

   // the previous level's result leaves once this level shows whether it made one too
   assign a_fire    = a_valid_ff && !(a_has_prev_ff && fifo_full);
   assign push      = a_fire && a_has_prev_ff;
   assign req_ready = !b_valid_ff && (!a_valid_ff || (a_fire && !step.made));
   assign req_take  = req_valid && req_ready;

   always_comb begin
      push_data      = a_prev_ff;
      push_data.last = !step.made;
   end

   mmbd_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .full      (fifo_full),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   assign avg        = quad_average(mem_rd_data, b_held_ff, b_pixel_ff);
   assign next_level = b_level_ff + LEVEL_W'(1);

   always_comb begin
      cascade.level     = next_level;
      cascade.px        = b_px_ff;
      cascade.py        = b_py_ff;
      cascade.avg_red   = avg.red;
      cascade.avg_green = avg.green;
      cascade.avg_blue  = avg.blue;
      cascade.avg_alpha = avg.alpha;
      cascade.last      = 1'b0;
   end

   always_comb begin
      a_valid_in    = a_valid_ff;
      a_level_in    = a_level_ff;
      a_pixel_in    = a_pixel_ff;
      a_has_prev_in = a_has_prev_ff;
      a_prev_in     = a_prev_ff;
      if (b_valid_ff) begin
         // finished pixel becomes the next source pixel of the coarser level
         a_valid_in    = 1'b1;
         a_level_in    = next_level;
         a_pixel_in    = avg;
         a_has_prev_in = 1'b1;
         a_prev_in     = cascade;
      end else if (req_take) begin
         a_valid_in    = 1'b1;
         a_level_in    = '0;
         a_pixel_in    = req_data;
         a_has_prev_in = 1'b0;
      end else if (a_fire) begin
         a_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
      end else begin
         a_valid_ff <= a_valid_in;
         b_valid_ff <= a_fire && step.made;
      end
   end

   always_ff @(posedge clock) begin
      a_level_ff    <= a_level_in;
      a_pixel_ff    <= a_pixel_in;
      a_has_prev_ff <= a_has_prev_in;
      a_prev_ff     <= a_prev_in;
      if (a_fire && step.made) begin
         b_level_ff <= a_level_ff;
         b_px_ff    <= step.px;
         b_py_ff    <= step.py;
         b_held_ff  <= step.held;
         b_pixel_ff <= a_pixel_ff;
      end
   end

endmodule
